### rtl/bilinear_bayer_demosaic_unit_defines.svh
// ----------------------------------------------------------------------------
// Bilinear Bayer demosaic assertion macros
// Shared property templates for the demosaic checks, clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_BAYER_DEMOSAIC_UNIT_DEFINES_SVH
`define BILINEAR_BAYER_DEMOSAIC_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear Bayer demosaic package
// Sizes, register map, request and result types shared by the demosaic.
// ----------------------------------------------------------------------------
`default_nettype none

package bbd_pkg;

   localparam int MaxWidth      = 1024;
   localparam int ColBits       = $clog2(MaxWidth);
   localparam int EffWidthBits  = ColBits + 1;
   localparam int CfgWidthBits  = 11;
   localparam int CfgHeightBits = 16;
   localparam int RowBits       = CfgHeightBits + 1;
   localparam int PixelBits     = 8;
   localparam int CsrAddrBits   = 3;
   localparam int CsrDataBits   = 32;

   localparam logic KIND_RAW   = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   localparam logic CSR_IDX_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IDX_IMAGE_HEIGHT = 1'b1;

   localparam logic [CfgWidthBits-1:0]  ImageWidthReset  = CfgWidthBits'(390);
   localparam logic [CfgHeightBits-1:0] ImageHeightReset = CfgHeightBits'(300);

   typedef struct packed {
      logic                 kind;
      logic [PixelBits-1:0] raw_pixel;
   } req_payload_type;

   typedef struct packed {
      logic [PixelBits-1:0] red;
      logic [PixelBits-1:0] green;
      logic [PixelBits-1:0] blue;
      logic                 frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic emit_edge;
      logic emit_mid;
      logic shift;
      logic last;
      logic orow_odd;
      logic ocol_odd;
      logic top_mirror;
      logic bot_mirror;
      logic left_mirror;
   } bbd_ctl_type;

endpackage

`default_nettype wire

### rtl/bilinear_bayer_demosaic_unit.sv
// ----------------------------------------------------------------------------
// Bilinear Bayer demosaic unit
// Streams Bayer raw pixels in raster order and returns one RGB pixel per
// position, built by bilinear interpolation over a 3x3 window.
// ----------------------------------------------------------------------------
// The unit takes one request per clock and returns one pixel per clock in
// steady state while rsp_ready stays high. Each request but the last of a
// frame reads both stored lines at its column from a single line memory into
// rd_ff when it is accepted; when the window stage then fires, it shifts the
// window, writes the lines back and, if it emits, loads the result register.
// Results lag requests by width plus one, so width plus one flush requests
// must follow the last raw pixel of every frame; the last of them carries
// frame_end. There is no clearing pass after reset.
`default_nettype none
`include "bilinear_bayer_demosaic_unit_defines.svh"

module bilinear_bayer_demosaic_unit import bbd_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire req_payload_type        req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      rsp_payload_type        rsp_data,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CsrAddrBits-1:0] paddr,
   input  wire logic [CsrDataBits-1:0] pwdata,
   output      logic [CsrDataBits-1:0] prdata,
   output      logic                   pready
);

   logic [CfgWidthBits-1:0]  image_width_ff, image_width_in;
   logic [CfgHeightBits-1:0] image_height_ff, image_height_in;
   logic                     csr_write;
   logic                     csr_index;

   logic [EffWidthBits-1:0]  w_eff;
   logic [CfgHeightBits-1:0] h_eff;
   logic [RowBits-1:0]       h_ext;

   logic [ColBits-1:0]       col_ff, col_in;
   logic [RowBits-1:0]       row_ff, row_in;
   logic [EffWidthBits-1:0]  col_next;

   logic                     flushing;
   logic                     a_accept, a_enter, a_ignore;
   logic                     a_edge, a_last, a_mid;
   bbd_ctl_type              a_ctl;
   logic [PixelBits-1:0]     a_pix;

   logic [2*PixelBits-1:0]   line_mem [MaxWidth];
   logic [2*PixelBits-1:0]   rd_ff;

   logic                     b_valid_ff, b_valid_in;
   bbd_ctl_type              b_ctl_ff;
   logic [PixelBits-1:0]     b_pix_ff;
   logic [ColBits-1:0]       b_col_ff;
   logic                     b_emit, b_fire, out_free;

   logic [2:0][2:0][PixelBits-1:0] win_ff, win_in;
   logic [2:0][PixelBits-1:0] new_col, left_c, centre_c, right_c;
   logic [1:0]               ti, bi;
   logic [PixelBits-1:0]     ctr;
   logic [PixelBits:0]       hsum, vsum;
   logic [PixelBits+1:0]     dsum, gsum;
   rsp_payload_type          pixel;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_data_ff;

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2];

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IDX_IMAGE_WIDTH:  image_width_in  = pwdata[CfgWidthBits-1:0];
            CSR_IDX_IMAGE_HEIGHT: image_height_in = pwdata[CfgHeightBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_IDX_IMAGE_WIDTH:  prdata = CsrDataBits'(image_width_ff);
         CSR_IDX_IMAGE_HEIGHT: prdata = CsrDataBits'(image_height_ff);
         default:              prdata = '0;
      endcase
   end

   always_comb begin
      if (image_width_ff < CfgWidthBits'(2)) begin
         w_eff = EffWidthBits'(2);
      end else if (32'(image_width_ff) > MaxWidth) begin
         w_eff = EffWidthBits'(MaxWidth);
      end else begin
         w_eff = EffWidthBits'(image_width_ff);
      end
      h_eff = (image_height_ff < CfgHeightBits'(2)) ? CfgHeightBits'(2) : image_height_ff;
      h_ext = RowBits'(h_eff);
   end

   // Request side: position counters and per-request decisions.
   assign flushing  = row_ff >= h_ext;
   assign a_ignore  = (req_data.kind == KIND_FLUSH) && !flushing;
   assign a_accept  = req_valid && req_ready;
   assign a_enter   = a_accept && !a_ignore;
   assign a_edge    = (col_ff == '0) && (row_ff >= RowBits'(2));
   assign a_last    = a_edge && (row_ff >= h_ext + RowBits'(1));
   assign a_mid     = (col_ff != '0) && (row_ff != '0);
   assign a_pix     = flushing ? '0 : req_data.raw_pixel;
   assign col_next  = EffWidthBits'(col_ff) + EffWidthBits'(1);

   always_comb begin
      a_ctl.emit_edge   = a_edge;
      a_ctl.emit_mid    = a_mid;
      a_ctl.shift       = !a_last;
      a_ctl.last        = a_last;
      a_ctl.orow_odd    = a_edge ? row_ff[0] : ~row_ff[0];
      a_ctl.ocol_odd    = a_edge ? ~w_eff[0] : ~col_ff[0];
      a_ctl.top_mirror  = a_edge ? (row_ff == RowBits'(2)) : (row_ff == RowBits'(1));
      a_ctl.bot_mirror  = a_edge ? (row_ff == h_ext + RowBits'(1)) : (row_ff == h_ext);
      a_ctl.left_mirror = col_ff == ColBits'(1);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (a_enter) begin
         if (a_last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= w_eff) begin
            col_in = '0;
            row_in = row_ff + RowBits'(1);
         end else begin
            col_in = col_next[ColBits-1:0];
         end
      end
   end

   // Line memory: older line in the upper byte, newer line in the lower byte.
   always_ff @(posedge clock) begin
      if (a_enter && a_ctl.shift) begin
         rd_ff <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire && b_ctl_ff.shift) begin
         line_mem[b_col_ff] <= {rd_ff[PixelBits-1:0], b_pix_ff};
      end
   end

   // Window stage.
   assign b_emit     = b_ctl_ff.emit_edge || b_ctl_ff.emit_mid;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign b_fire     = b_valid_ff && (!b_emit || out_free);
   assign req_ready  = !b_valid_ff || b_fire;
   assign b_valid_in = a_enter ? 1'b1 : (b_fire ? 1'b0 : b_valid_ff);

   assign new_col[0] = rd_ff[2*PixelBits-1:PixelBits];
   assign new_col[1] = rd_ff[PixelBits-1:0];
   assign new_col[2] = b_pix_ff;

   always_comb begin
      win_in = win_ff;
      if (b_fire && b_ctl_ff.shift) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
            win_in[r][2] = new_col[r];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         centre_c[r] = win_ff[r][2];
         if (b_ctl_ff.emit_edge) begin
            left_c[r]  = win_ff[r][1];
            right_c[r] = win_ff[r][1];
         end else begin
            left_c[r]  = b_ctl_ff.left_mirror ? new_col[r] : win_ff[r][1];
            right_c[r] = new_col[r];
         end
      end
      ti   = b_ctl_ff.top_mirror ? 2'd2 : 2'd0;
      bi   = b_ctl_ff.bot_mirror ? 2'd0 : 2'd2;
      ctr  = centre_c[1];
      hsum = (PixelBits+1)'(left_c[1]) + (PixelBits+1)'(right_c[1]);
      vsum = (PixelBits+1)'(centre_c[ti]) + (PixelBits+1)'(centre_c[bi]);
      dsum = (PixelBits+2)'(left_c[ti]) + (PixelBits+2)'(right_c[ti])
           + (PixelBits+2)'(left_c[bi]) + (PixelBits+2)'(right_c[bi]);
      gsum = (PixelBits+2)'(hsum) + (PixelBits+2)'(vsum);

      pixel.frame_end = b_ctl_ff.last;
      if (b_ctl_ff.orow_odd == b_ctl_ff.ocol_odd) begin
         pixel.green = ctr;
         if (!b_ctl_ff.orow_odd) begin
            pixel.red  = hsum[PixelBits:1];
            pixel.blue = vsum[PixelBits:1];
         end else begin
            pixel.blue = hsum[PixelBits:1];
            pixel.red  = vsum[PixelBits:1];
         end
      end else if (!b_ctl_ff.orow_odd) begin
         pixel.red   = ctr;
         pixel.green = gsum[PixelBits+1:2];
         pixel.blue  = dsum[PixelBits+1:2];
      end else begin
         pixel.blue  = ctr;
         pixel.green = gsum[PixelBits+1:2];
         pixel.red   = dsum[PixelBits+1:2];
      end
   end

   // Result register.
   always_comb begin
      if (b_fire && b_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= ImageWidthReset;
         image_height_ff <= ImageHeightReset;
         col_ff          <= '0;
         row_ff          <= '0;
         b_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         win_ff          <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         b_valid_ff      <= b_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         win_ff          <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_enter) begin
         b_ctl_ff <= a_ctl;
         b_pix_ff <= a_pix;
         b_col_ff <= col_ff;
      end
      if (b_fire && b_emit) begin
         rsp_data_ff <= pixel;
      end
   end

   `BBD_ASSERT_SAME(a_stall_only_when_held, !req_ready, b_valid_ff && !b_fire, "Request stalled with window stage free")
   `BBD_ASSERT_SAME(a_silent_stage_drains, b_valid_ff && !b_emit, b_fire, "Window stage without result failed to advance")
   `BBD_ASSERT_NEXT(a_frame_end_clears, a_enter && a_last, row_ff == '0 && col_ff == '0, "Counters not cleared after frame end")

endmodule

`default_nettype wire
